// File: rtl/qspims_pkg.sv
// shared types, codes and constants for the quad spi master serializer
`default_nettype none

package qspims_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] ACT_SINGLE = 3'd0;
  localparam logic [2:0] ACT_QREAD  = 3'd1;
  localparam logic [2:0] ACT_DREAD  = 3'd2;
  localparam logic [2:0] ACT_QWRITE = 3'd3;
  localparam logic [2:0] ACT_TICK   = 3'd4;

  localparam logic [3:0] CLKS_SINGLE = 4'd8;
  localparam logic [3:0] CLKS_QUAD   = 4'd2;
  localparam logic [3:0] CLKS_DUAL   = 4'd4;

  localparam logic [3:0] DRIVE_RESET = 4'hC;
  localparam logic [3:0] DIR_SINGLE  = 4'hD;
  localparam logic [3:0] DIR_NONE    = 4'h0;
  localparam logic [3:0] DIR_ALL     = 4'hF;
  localparam logic [3:0] DIR_UPPER   = 4'hC;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_QREAD  = 2'd1,
    MODE_DREAD  = 2'd2,
    MODE_QWRITE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic [3:0] lines_in;
  } cmd_t;

  typedef struct packed {
    logic [3:0] lines_out;
    logic [3:0] lines_enable;
    logic       busy_res;
    logic       byte_done;
    logic [7:0] rx_byte;
    logic       rejected;
  } rsp_t;

  typedef struct packed {
    op_t        op;
    mode_t      mode;
    logic [7:0] tx_byte;
    logic [3:0] lines_in;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/qspims_front.sv
// front end: takes command words and sorts them into start, tick or no-op entries
`default_nettype none

module qspims_front (
  input  qspims_pkg::cmd_t   cmd,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic               q_full,
  output logic               push,
  output qspims_pkg::entry_t push_data
);
  import qspims_pkg::*;

  assign cmd_stall = q_full;
  assign push      = cmd_valid && !q_full;

  always_comb begin
    push_data.tx_byte  = cmd.tx_byte;
    push_data.lines_in = cmd.lines_in;
    push_data.mode     = mode_t'(cmd.action[1:0]);
    unique case (cmd.action)
      ACT_SINGLE, ACT_QREAD, ACT_DREAD, ACT_QWRITE: push_data.op = OP_START;
      ACT_TICK:                                     push_data.op = OP_TICK;
      default:                                      push_data.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/qspims_queue.sv
// short queue of decoded entries between front and back
`default_nettype none

module qspims_queue #(
  parameter int unsigned DEPTH = qspims_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  qspims_pkg::entry_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output qspims_pkg::entry_t head
);
  import qspims_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

// File: rtl/qspims_back.sv
// back end: shifter state, line drive and enables, registered result word
`default_nettype none

module qspims_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  qspims_pkg::entry_t head,
  output logic               pop,
  output qspims_pkg::rsp_t   rsp,
  output logic               rsp_valid,
  input  logic               rsp_stall
);
  import qspims_pkg::*;

  mode_t      mode, mode_next;
  logic [7:0] out_shift, out_shift_next;
  logic [7:0] in_shift, in_shift_next;
  logic [3:0] clocks_left, clocks_left_next;
  logic [3:0] line_drive, line_drive_next;
  logic [3:0] line_dir, line_dir_next;
  logic       done;
  logic       rej;
  logic [7:0] rx;

  assign pop = head_valid && (!rsp_valid || !rsp_stall);

  always_comb begin
    mode_next        = mode;
    out_shift_next   = out_shift;
    in_shift_next    = in_shift;
    clocks_left_next = clocks_left;
    line_drive_next  = line_drive;
    line_dir_next    = line_dir;
    done             = 1'b0;
    rej              = 1'b0;
    rx               = '0;
    unique case (head.op)
      OP_START: begin
        if (clocks_left != '0) begin
          rej = 1'b1;
        end else begin
          mode_next      = head.mode;
          in_shift_next  = '0;
          out_shift_next = head.tx_byte;
          unique case (head.mode)
            MODE_SINGLE: begin
              clocks_left_next = CLKS_SINGLE;
              line_dir_next    = DIR_SINGLE;
              line_drive_next  = {DRIVE_RESET[3:1], head.tx_byte[7]};
            end
            MODE_QREAD: begin
              clocks_left_next = CLKS_QUAD;
              line_dir_next    = DIR_NONE;
            end
            MODE_DREAD: begin
              clocks_left_next = CLKS_DUAL;
              line_dir_next    = line_dir & DIR_UPPER;
            end
            MODE_QWRITE: begin
              clocks_left_next = CLKS_QUAD;
              line_dir_next    = DIR_ALL;
              line_drive_next  = head.tx_byte[7:4];
            end
          endcase
        end
      end
      OP_TICK: begin
        if (clocks_left != '0) begin
          unique case (mode)
            MODE_SINGLE: begin
              in_shift_next  = {in_shift[6:0], head.lines_in[1]};
              out_shift_next = {out_shift[6:0], 1'b0};
            end
            MODE_QREAD:  in_shift_next = {in_shift[3:0], head.lines_in};
            MODE_DREAD:  in_shift_next = {in_shift[5:0], head.lines_in[1:0]};
            MODE_QWRITE: in_shift_next = in_shift;
          endcase
          clocks_left_next = clocks_left - 1'b1;
          if (clocks_left_next != '0) begin
            if (mode == MODE_SINGLE) begin
              line_drive_next = {line_drive[3:1], out_shift_next[7]};
            end else if (mode == MODE_QWRITE) begin
              line_drive_next = out_shift[3:0];
            end
          end else begin
            done = 1'b1;
            rx   = (mode == MODE_QWRITE) ? 8'h00 : in_shift_next;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_SINGLE;
      out_shift   <= '0;
      in_shift    <= '0;
      clocks_left <= '0;
      line_drive  <= DRIVE_RESET;
      line_dir    <= DIR_SINGLE;
      rsp_valid   <= 1'b0;
    end else begin
      if (pop) begin
        mode        <= mode_next;
        out_shift   <= out_shift_next;
        in_shift    <= in_shift_next;
        clocks_left <= clocks_left_next;
        line_drive  <= line_drive_next;
        line_dir    <= line_dir_next;
        rsp_valid   <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp.lines_out    <= line_drive_next;
      rsp.lines_enable <= line_dir_next;
      rsp.busy_res     <= (clocks_left_next != '0);
      rsp.byte_done    <= done;
      rsp.rx_byte      <= rx;
      rsp.rejected     <= rej;
    end
  end

  a_clocks_bound: assert property (@(posedge clk) disable iff (rst)
    clocks_left <= CLKS_SINGLE)
    else $error("clock count out of range");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.byte_done |-> !rsp.busy_res && !rsp.rejected)
    else $error("completed word still busy or rejected");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.rejected |-> rsp.busy_res && clocks_left != '0)
    else $error("rejected start while idle");

endmodule

`default_nettype wire

// File: rtl/quad_spi_master_serializer.sv
// quad spi master byte serializer, top level
//
// command channel (cmd_valid, cmd_stall, cmd): one word per action; a start
// loads a byte and a transfer mode, a tick advances the shifter by one
// serial clock period and samples cmd.lines_in.
// response channel (rsp_valid, rsp_stall, rsp): exactly one word per
// command word, in order, with line drive values and enables for the next
// period, busy flag, byte completion with the assembled byte, and a reject
// flag for a start that arrived while a byte was still shifting.
// a command word is written into the queue at the accept edge, and its shifter
// update is written into the response register when the back end pops it
// from the queue; one command word is taken every cycle while cmd_stall is
// low.
// when rsp_stall is held the response register keeps its word, the queue
// fills, and cmd_stall rises once the queue is full.
// reset (rst, synchronous) empties the queue, drops rsp_valid and returns
// the shifter to idle single mode with lines 2 and 3 driven high and line 1
// as an input.
`default_nettype none

module quad_spi_master_serializer #(
  parameter int unsigned QUEUE_DEPTH = qspims_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  qspims_pkg::cmd_t cmd,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output qspims_pkg::rsp_t rsp
);
  import qspims_pkg::*;

  logic   push;
  entry_t push_data;
  logic   q_full;
  logic   pop;
  logic   head_valid;
  entry_t head;

  qspims_front u_front (
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  qspims_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  qspims_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rsp        (rsp),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall)
  );

endmodule

`default_nettype wire
